// File: rtl/core/krle_pkg.sv
// Package for the key repeat line editor.
// Holds widths, key and event codes, layer byte tables and the shift command type.
// No dependencies.
package krle_pkg;

  // Store geometry
  localparam int TEXT_DEPTH = 256;
  localparam int ADDR_W     = $clog2(TEXT_DEPTH);
  localparam int POS_W      = 8;
  localparam int BYTE_W     = 8;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int KEY_W   = 6;
  localparam int EDIT_W  = 2;
  localparam int LAYER_W = 2;
  localparam int CNT_W   = 21;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_NONE         = 6'd0;
  localparam logic [KEY_W-1:0] KEY_ACCEPT       = 6'd1;
  localparam logic [KEY_W-1:0] KEY_SHIFT        = 6'd2;
  localparam logic [KEY_W-1:0] KEY_SUPER        = 6'd3;
  localparam logic [KEY_W-1:0] KEY_FN           = 6'd4;
  localparam logic [KEY_W-1:0] KEY_LETTER_FIRST = 6'd5;
  localparam logic [KEY_W-1:0] KEY_LETTER_LAST  = 6'd30;
  localparam logic [KEY_W-1:0] KEY_SPACE        = 6'd31;
  localparam logic [KEY_W-1:0] KEY_BACKSPACE    = 6'd32;
  localparam logic [KEY_W-1:0] KEY_DELETE       = 6'd33;
  localparam logic [KEY_W-1:0] KEY_RETURN       = 6'd34;
  localparam logic [KEY_W-1:0] KEY_ARROW_FIRST  = 6'd35;
  localparam logic [KEY_W-1:0] KEY_ARROW_LAST   = 6'd38;

  // Edit report codes
  localparam logic [EDIT_W-1:0] EDIT_NONE   = 2'd0;
  localparam logic [EDIT_W-1:0] EDIT_INSERT = 2'd1;
  localparam logic [EDIT_W-1:0] EDIT_REMOVE = 2'd2;

  // Layers
  localparam logic [LAYER_W-1:0] LAYER_LOWER  = 2'd0;
  localparam logic [LAYER_W-1:0] LAYER_UPPER  = 2'd1;
  localparam logic [LAYER_W-1:0] LAYER_NUMBER = 2'd2;
  localparam logic [LAYER_W-1:0] LAYER_SYMBOL = 2'd3;

  // Register indexes and reset values
  localparam logic [1:0] REG_LONG_HOLD  = 2'd0;
  localparam logic [1:0] REG_ARROW_HOLD = 2'd1;
  localparam logic [1:0] REG_REPEAT     = 2'd2;

  localparam logic [CNT_W-1:0] LONG_HOLD_RESET  = 21'd1000000;
  localparam logic [CNT_W-1:0] ARROW_HOLD_RESET = 21'd250000;
  localparam logic [CNT_W-1:0] REPEAT_RESET     = 21'd125000;

  localparam logic [BYTE_W-1:0] BYTE_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] BYTE_NEWLINE = 8'h0A;

  localparam int LETTER_COUNT = 26;

  // Letter bytes per layer; symbol row carries the em dash as raw UTF-8
  localparam logic [BYTE_W-1:0] LAYER_TAB [4][LETTER_COUNT] = '{
    '{8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h7A,
      8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D},
    '{8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h5A,
      8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D},
    '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
      8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h3B, 8'h27, 8'h5B, 8'h5D, 8'h5C, 8'h2E,
      8'h2E, 8'h2D, 8'h3D, 8'h2C, 8'h2E, 8'h2F},
    '{8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
      8'h2E, 8'h2E, 8'h2E, 8'h2E, 8'h3A, 8'h22, 8'h7B, 8'h7D, 8'h7C, 8'h2E,
      8'h3F, 8'hE2, 8'h80, 8'h94, 8'h2B, 8'h3C}
  };

  function automatic logic [BYTE_W-1:0] layer_byte(input logic [LAYER_W-1:0] layer,
                                                   input logic [4:0] idx);
    logic [BYTE_W-1:0] b;
    b = '0;
    if (idx < 5'(LETTER_COUNT)) begin
      b = LAYER_TAB[layer][idx];
    end
    return b;
  endfunction

  // Request to the shift engine: move bytes from first to last, then write fill
  typedef struct packed {
    logic              go;
    logic              ins;
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] last;
    logic [ADDR_W-1:0] fill_addr;
    logic [BYTE_W-1:0] fill_byte;
  } shift_cmd_t;

endpackage

// File: rtl/core/krle_shift.sv
// Text store and its shift engine: one byte moved per cycle, then one fill write.
// Clears the store after reset, one entry per cycle.
// Depends on krle_pkg.
module krle_shift (
  input  logic                  clk,
  input  logic                  rst,
  input  krle_pkg::shift_cmd_t  cmd,
  output logic                  busy
);
  import krle_pkg::*;

  localparam logic [1:0] SH_CLEAR = 2'd0;
  localparam logic [1:0] SH_IDLE  = 2'd1;
  localparam logic [1:0] SH_MOVE  = 2'd2;
  localparam logic [1:0] SH_FILL  = 2'd3;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TEXT_DEPTH - 1);

  logic [BYTE_W-1:0] mem [TEXT_DEPTH];

  logic [1:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] src;
  logic [ADDR_W-1:0] last;
  logic [ADDR_W-1:0] rd_src;
  logic [ADDR_W-1:0] fill_addr;
  logic [BYTE_W-1:0] fill_byte;
  logic [BYTE_W-1:0] rd_data;
  logic              ins;
  logic              rd_pend;
  logic              reads_done;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SH_CLEAR;
      clr_addr   <= '0;
      rd_pend    <= 1'b0;
      reads_done <= 1'b0;
    end else begin
      unique case (state)
        SH_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ADDR) begin
            state <= SH_IDLE;
          end
        end
        SH_IDLE: begin
          if (cmd.go) begin
            src        <= cmd.first;
            last       <= cmd.last;
            ins        <= cmd.ins;
            fill_addr  <= cmd.fill_addr;
            fill_byte  <= cmd.fill_byte;
            rd_pend    <= 1'b0;
            reads_done <= 1'b0;
            state      <= SH_MOVE;
          end
        end
        SH_MOVE: begin
          rd_pend <= !reads_done;
          rd_src  <= src;
          if (!reads_done) begin
            if (src == last) begin
              reads_done <= 1'b1;
            end else begin
              src <= ins ? src - 1'b1 : src + 1'b1;
            end
          end
          if (reads_done && rd_pend) begin
            state <= SH_FILL;
          end
        end
        SH_FILL: begin
          state <= SH_IDLE;
        end
        default: begin
          state <= SH_IDLE;
        end
      endcase
    end
  end

  // Write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      SH_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      SH_MOVE: begin
        wr_en   = rd_pend;
        wr_addr = ins ? rd_src + 1'b1 : rd_src - 1'b1;
        wr_data = rd_data;
      end
      SH_FILL: begin
        wr_en   = 1'b1;
        wr_addr = fill_addr;
        wr_data = fill_byte;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Store: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[src];
  end

  assign busy = (state != SH_IDLE);

endmodule

// File: rtl/core/key_repeat_line_editor.sv
// Key repeat line editor, top level: event decode, repeat timing, APB registers.
// Instantiates krle_shift for the text store; depends on krle_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------
//   input   | in        | in_valid/in_stall  | kind, key_code
//   output  | out       | out_valid/out_stall| edit_kind .. repeat_fired
//   config  | in        | APB psel/penable   | paddr, pwdata, prdata
//
// An event is decoded in the execute state and its result is loaded in the finish
// state; an insert or removal waits there while the shift engine moves the text.
// After reset the store is cleared; in_stall is high meanwhile.
// One result waits in the output register while the next request is decoded;
// a held out_stall stops the block only when a second result is ready.
module key_repeat_line_editor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [krle_pkg::PADDR_W-1:0]    paddr,
  input  logic [krle_pkg::PDATA_W-1:0]    pwdata,
  output logic [krle_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [krle_pkg::KIND_W-1:0]     kind,
  input  logic [krle_pkg::KEY_W-1:0]      key_code,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [krle_pkg::EDIT_W-1:0]     edit_kind,
  output logic [krle_pkg::POS_W-1:0]      edit_pos,
  output logic [krle_pkg::BYTE_W-1:0]     edit_byte,
  output logic [krle_pkg::POS_W-1:0]      text_length,
  output logic [krle_pkg::POS_W-1:0]      cursor_now,
  output logic [krle_pkg::LAYER_W-1:0]    layer_now,
  output logic                            accepted,
  output logic                            repeat_fired
);
  import krle_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]          state;
  logic [KIND_W-1:0]   in_kind;
  logic [KEY_W-1:0]    in_key;

  logic [POS_W-1:0]    length_count, length_next;
  logic [POS_W-1:0]    cursor_pos, cursor_next;
  logic [LAYER_W-1:0]  layer_sel, layer_next;
  logic [KEY_W-1:0]    held_key, held_next;
  logic [CNT_W-1:0]    hold_elapsed, hold_next;
  logic [CNT_W-1:0]    press_elapsed, press_next;
  logic                accept_flag, accept_next;

  logic [CNT_W-1:0]    long_hold_delay;
  logic [CNT_W-1:0]    arrow_hold_delay;
  logic [CNT_W-1:0]    repeat_interval;

  // Result held until the store settles
  logic [EDIT_W-1:0]   pend_kind, ek;
  logic [POS_W-1:0]    pend_pos, ep;
  logic [BYTE_W-1:0]   pend_byte, eb;
  logic                pend_fired, fire;

  logic [CNT_W-1:0]    hold_inc, press_inc;
  logic                is_arrow, do_press, letter;
  logic [KEY_W-1:0]    pk;
  logic                ins_req, rm_req, rm_before;
  logic [BYTE_W-1:0]   ins_byte;
  logic                room, ins_ok, rm_ok;
  logic [POS_W-1:0]    rm_at;

  shift_cmd_t          sh_cmd;
  logic                sh_busy;
  logic                accept_in, load_out, cfg_wr;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign in_stall  = (state != ST_IDLE) || sh_busy;
  assign accept_in = in_valid && !in_stall;
  assign load_out  = (state == ST_FINISH) && !sh_busy && (!out_valid || !out_stall);

  krle_shift u_shift (
    .clk  (clk),
    .rst  (rst),
    .cmd  (sh_cmd),
    .busy (sh_busy)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      long_hold_delay  <= LONG_HOLD_RESET;
      arrow_hold_delay <= ARROW_HOLD_RESET;
      repeat_interval  <= REPEAT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LONG_HOLD:  long_hold_delay  <= pwdata[CNT_W-1:0];
        REG_ARROW_HOLD: arrow_hold_delay <= pwdata[CNT_W-1:0];
        REG_REPEAT:     repeat_interval  <= pwdata[CNT_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LONG_HOLD:  prdata = PDATA_W'(long_hold_delay);
      REG_ARROW_HOLD: prdata = PDATA_W'(arrow_hold_delay);
      REG_REPEAT:     prdata = PDATA_W'(repeat_interval);
      default:        prdata = '0;
    endcase
  end

  // Event decode and state update
  always_comb begin
    length_next = length_count;
    cursor_next = cursor_pos;
    layer_next  = layer_sel;
    held_next   = held_key;
    hold_next   = hold_elapsed;
    press_next  = press_elapsed;
    accept_next = accept_flag;
    ek          = EDIT_NONE;
    ep          = '0;
    eb          = '0;
    sh_cmd      = '0;
    ins_req     = 1'b0;
    rm_req      = 1'b0;
    rm_before   = 1'b0;
    ins_byte    = '0;

    hold_inc  = (hold_elapsed == CNT_MAX) ? hold_elapsed : hold_elapsed + 1'b1;
    press_inc = (press_elapsed == CNT_MAX) ? press_elapsed : press_elapsed + 1'b1;
    is_arrow  = (held_key >= KEY_ARROW_FIRST) && (held_key <= KEY_ARROW_LAST);
    fire      = (in_kind == KIND_TICK) && (held_key != KEY_NONE) &&
                ((hold_inc > long_hold_delay) ||
                 (is_arrow && (hold_inc > arrow_hold_delay))) &&
                (press_inc > repeat_interval);
    do_press  = (in_kind == KIND_PRESS) || fire;
    pk        = (in_kind == KIND_PRESS) ? in_key : held_key;
    letter    = (pk >= KEY_LETTER_FIRST) && (pk <= KEY_LETTER_LAST);

    // tick advances both counters before any repeat
    if (in_kind == KIND_TICK) begin
      hold_next  = hold_inc;
      press_next = press_inc;
    end

    if (in_kind == KIND_RELEASE) begin
      if (in_key == KEY_SHIFT || in_key == KEY_SUPER || in_key == KEY_FN) begin
        layer_next = LAYER_LOWER;
      end
      if (held_key == in_key) begin
        held_next = KEY_NONE;
      end
    end

    if (do_press) begin
      press_next = '0;
      priority if (pk == KEY_ACCEPT) begin
        accept_next = 1'b1;
      end else if (pk == KEY_SHIFT) begin
        layer_next = LAYER_UPPER;
      end else if (pk == KEY_SUPER) begin
        layer_next = LAYER_NUMBER;
      end else if (pk == KEY_FN) begin
        layer_next = LAYER_SYMBOL;
      end else if (letter) begin
        ins_req  = 1'b1;
        ins_byte = layer_byte(layer_sel, 5'(pk - KEY_LETTER_FIRST));
      end else if (pk == KEY_SPACE) begin
        ins_req  = 1'b1;
        ins_byte = BYTE_SPACE;
      end else if (pk == KEY_BACKSPACE) begin
        rm_req    = 1'b1;
        rm_before = 1'b1;
      end else if (pk == KEY_DELETE) begin
        rm_req = 1'b1;
      end else if (pk == KEY_RETURN) begin
        ins_req  = 1'b1;
        ins_byte = BYTE_NEWLINE;
      end else begin
        ins_req = 1'b0;
      end
      if (pk != KEY_SHIFT && pk != held_key) begin
        held_next = pk;
        hold_next = '0;
      end
    end

    // insert: tail moves up one byte, new byte lands at the cursor
    room   = ({1'b0, length_count} + (POS_W+1)'(2)) < (POS_W+1)'(TEXT_DEPTH);
    ins_ok = ins_req && room && (cursor_pos <= length_count);
    // remove: tail moves down one byte, vacated end slot is zeroed
    rm_ok  = rm_req && (cursor_pos <= length_count) &&
             (rm_before ? (cursor_pos != '0) : (cursor_pos != length_count));
    rm_at  = rm_before ? cursor_pos - 1'b1 : cursor_pos;

    if (ins_ok) begin
      ek          = EDIT_INSERT;
      ep          = cursor_pos;
      eb          = ins_byte;
      cursor_next = cursor_pos + 1'b1;
      length_next = length_count + 1'b1;
      sh_cmd.ins       = 1'b1;
      sh_cmd.first     = length_count[ADDR_W-1:0];
      sh_cmd.last      = cursor_pos[ADDR_W-1:0];
      sh_cmd.fill_addr = cursor_pos[ADDR_W-1:0];
      sh_cmd.fill_byte = ins_byte;
    end else if (rm_ok) begin
      ek          = EDIT_REMOVE;
      ep          = rm_at;
      cursor_next = rm_at;
      length_next = length_count - 1'b1;
      sh_cmd.ins       = 1'b0;
      sh_cmd.first     = rm_at[ADDR_W-1:0] + 1'b1;
      sh_cmd.last      = length_count[ADDR_W-1:0];
      sh_cmd.fill_addr = length_count[ADDR_W-1:0];
      sh_cmd.fill_byte = '0;
    end
    sh_cmd.go = (state == ST_EXEC) && (ins_ok || rm_ok);
  end

  // Control sequence and editor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      length_count  <= '0;
      cursor_pos    <= '0;
      layer_sel     <= LAYER_LOWER;
      held_key      <= KEY_NONE;
      hold_elapsed  <= '0;
      press_elapsed <= '0;
      accept_flag   <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept_in) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          length_count  <= length_next;
          cursor_pos    <= cursor_next;
          layer_sel     <= layer_next;
          held_key      <= held_next;
          hold_elapsed  <= hold_next;
          press_elapsed <= press_next;
          accept_flag   <= accept_next;
          state         <= ST_FINISH;
        end
        ST_FINISH: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept_in) begin
      in_kind <= kind;
      in_key  <= key_code;
    end
    if (state == ST_EXEC) begin
      pend_kind  <= ek;
      pend_pos   <= ep;
      pend_byte  <= eb;
      pend_fired <= fire;
    end
    if (load_out) begin
      edit_kind    <= pend_kind;
      edit_pos     <= pend_pos;
      edit_byte    <= pend_byte;
      text_length  <= length_count;
      cursor_now   <= cursor_pos;
      layer_now    <= layer_sel;
      accepted     <= accept_flag;
      repeat_fired <= pend_fired;
    end
  end

  // Checks
  a_cursor_in_text: assert property (@(posedge clk) disable iff (rst)
    cursor_pos <= length_count)
    else $error("cursor beyond text length");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, length_count} < (POS_W+1)'(TEXT_DEPTH - 1))
    else $error("text length exceeds store");

  a_shift_free: assert property (@(posedge clk) disable iff (rst)
    sh_cmd.go |-> !sh_busy)
    else $error("shift request while store busy");

  a_accept_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(accept_flag))
    else $error("accept flag dropped");

endmodule
